>>> rtl/core/vic_pkg.sv
// ----------------------------------------------------------------------------
// vic_pkg
// Shared types, register map and constants of the vectored interrupt
// controller.
// ----------------------------------------------------------------------------
package vic_pkg;

  localparam int VIC_NUM_SOURCES = 32;
  localparam int VIC_NUM_VECTORS = 16;

  localparam int VIC_DATA_W = 32;
  localparam int VIC_OFF_W  = 12;
  localparam int VIC_CTRL_W = 6;
  localparam int VIC_SLOT_W = 4;
  // slots 0..15 plus the default level
  localparam int VIC_IS_W   = 17;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_IDLE  = 2'd2;

  localparam logic [11:0] REG_IRQ_STATUS = 12'h000;
  localparam logic [11:0] REG_FIQ_STATUS = 12'h004;
  localparam logic [11:0] REG_RAW_STATUS = 12'h008;
  localparam logic [11:0] REG_SELECT     = 12'h00C;
  localparam logic [11:0] REG_ENABLE     = 12'h010;
  localparam logic [11:0] REG_ENABLE_CLR = 12'h014;
  localparam logic [11:0] REG_SOFT       = 12'h018;
  localparam logic [11:0] REG_SOFT_CLR   = 12'h01C;
  localparam logic [11:0] REG_PROTECT    = 12'h020;
  localparam logic [11:0] REG_VECT_ADDR  = 12'h030;
  localparam logic [11:0] REG_DEF_VECT   = 12'h034;
  localparam logic [11:0] REG_SLOT_ADDR  = 12'h100;
  localparam logic [11:0] REG_SLOT_CTRL  = 12'h200;
  localparam logic [11:0] REG_ID_BASE    = 12'hFE0;

  localparam int SLOT_EN_BIT = 5;

  localparam logic [7:0] VIC_ID_BYTES [8] = '{
    8'h90, 8'h11, 8'h04, 8'h00, 8'h0D, 8'hF0, 8'h05, 8'hB1
  };

  typedef struct packed {
    logic [1:0]            opcode;
    logic [VIC_OFF_W-1:0]  reg_offset;
    logic [VIC_DATA_W-1:0] write_data;
    logic                  privileged;
    logic [VIC_DATA_W-1:0] source_levels;
  } vic_item_t;

  typedef struct packed {
    logic [VIC_DATA_W-1:0] read_data;
    logic                  irq_request;
    logic                  fiq_request;
    logic                  access_refused;
  } vic_result_t;

  typedef struct packed {
    logic                  found;
    logic                  is_default;
    logic [VIC_SLOT_W-1:0] slot_idx;
  } vic_prio_t;

endpackage

>>> rtl/core/vic_in_if.sv
// ----------------------------------------------------------------------------
// vic_in_if
// Access channel into the interrupt controller: one bus access or idle cycle
// per transfer.
// ----------------------------------------------------------------------------
interface vic_in_if;
  import vic_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic [VIC_OFF_W-1:0]  reg_offset;
  logic [VIC_DATA_W-1:0] write_data;
  logic                  privileged;
  logic [VIC_DATA_W-1:0] source_levels;

  modport source (
    output valid, opcode, reg_offset, write_data, privileged, source_levels,
    input  ready
  );
  modport sink (
    input  valid, opcode, reg_offset, write_data, privileged, source_levels,
    output ready
  );
endinterface

>>> rtl/core/vic_out_if.sv
// ----------------------------------------------------------------------------
// vic_out_if
// Result channel of the interrupt controller: read data and request lines.
// ----------------------------------------------------------------------------
interface vic_out_if;
  import vic_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VIC_DATA_W-1:0] read_data;
  logic                  irq_request;
  logic                  fiq_request;
  logic                  access_refused;

  modport source (
    output valid, read_data, irq_request, fiq_request, access_refused,
    input  ready
  );
  modport sink (
    input  valid, read_data, irq_request, fiq_request, access_refused,
    output ready
  );
endinterface

>>> rtl/core/vic_prio.sv
// ----------------------------------------------------------------------------
// vic_prio
// Vector priority search: finds the highest eligible slot below the current
// in-service level, or the default level when no slot is found, nothing is in
// service and a pending IRQ source is claimed by no enabled slot.
// ----------------------------------------------------------------------------
module vic_prio #(
  parameter int NUM_VECTORS = vic_pkg::VIC_NUM_VECTORS
) (
  input  logic [vic_pkg::VIC_CTRL_W-1:0] slot_ctrl [NUM_VECTORS],
  input  logic [vic_pkg::VIC_IS_W-1:0]   in_service,
  input  logic [vic_pkg::VIC_DATA_W-1:0] irq_status,
  output vic_pkg::vic_prio_t             prio
);
  import vic_pkg::*;

  logic [VIC_DATA_W-1:0] claimed;
  logic                  blocked;
  logic                  found;
  logic [VIC_SLOT_W-1:0] idx;

  always_comb begin
    claimed = '0;
    blocked = 1'b0;
    found   = 1'b0;
    idx     = '0;
    for (int i = 0; i < NUM_VECTORS; i++) begin
      // a slot is blocked once any level at or above it is in service
      blocked = blocked | in_service[i];
      if (slot_ctrl[i][SLOT_EN_BIT]) begin
        claimed[slot_ctrl[i][4:0]] = 1'b1;
        if (!blocked && !found && irq_status[slot_ctrl[i][4:0]]) begin
          found = 1'b1;
          idx   = VIC_SLOT_W'(i);
        end
      end
    end
  end

  assign prio.found      = found;
  assign prio.slot_idx   = idx;
  assign prio.is_default = !found && (in_service == '0) && |(irq_status & ~claimed);

endmodule

>>> rtl/core/vic_regs.sv
// ----------------------------------------------------------------------------
// vic_regs
// Register file and access decode: applies one access to the controller
// state and forms the result of that access.
// ----------------------------------------------------------------------------
module vic_regs #(
  parameter int NUM_SOURCES = vic_pkg::VIC_NUM_SOURCES,
  parameter int NUM_VECTORS = vic_pkg::VIC_NUM_VECTORS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           advance,
  input  vic_pkg::vic_item_t             item,
  input  logic [vic_pkg::VIC_DATA_W-1:0] src_present,
  output vic_pkg::vic_result_t           result
);
  import vic_pkg::*;

  localparam int          IdxW    = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
  localparam logic [32:0] SrcFull = (33'd1 << NUM_SOURCES) - 33'd1;
  localparam logic [31:0] SrcMask = SrcFull[31:0];

  logic [VIC_DATA_W-1:0] soft_r, soft_nxt;
  logic [VIC_DATA_W-1:0] enable_r, enable_nxt;
  logic [VIC_DATA_W-1:0] select_r, select_nxt;
  logic                  protect_r, protect_nxt;
  logic [VIC_DATA_W-1:0] def_vect_r, def_vect_nxt;
  logic [VIC_IS_W-1:0]   in_service_r, in_service_nxt;
  logic [VIC_DATA_W-1:0] slot_addr_r [NUM_VECTORS];
  logic [VIC_DATA_W-1:0] slot_addr_nxt [NUM_VECTORS];
  logic [VIC_CTRL_W-1:0] slot_ctrl_r [NUM_VECTORS];
  logic [VIC_CTRL_W-1:0] slot_ctrl_nxt [NUM_VECTORS];

  logic [VIC_OFF_W-1:0]  off;
  logic                  refused;
  logic                  do_read;
  logic                  do_write;
  logic                  slot_ok;
  logic                  in_addr_rng;
  logic                  in_ctrl_rng;
  logic [VIC_DATA_W-1:0] raw_cur;
  logic [VIC_DATA_W-1:0] irq_cur;
  logic [VIC_DATA_W-1:0] raw_new;
  logic [VIC_DATA_W-1:0] irq_new;
  logic [VIC_SLOT_W-1:0] rd_idx;
  logic [VIC_DATA_W-1:0] slot_addr_q;
  logic [VIC_DATA_W-1:0] rd_data;
  vic_prio_t             prio_cur;
  vic_prio_t             prio_new;

  assign off         = {item.reg_offset[VIC_OFF_W-1:2], 2'b00};
  assign refused     = ((item.opcode == OP_READ) || (item.opcode == OP_WRITE)) &&
                       !item.privileged && (protect_r || off == REG_PROTECT);
  assign do_read     = (item.opcode == OP_READ) && !refused;
  assign do_write    = (item.opcode == OP_WRITE) && !refused;
  assign in_addr_rng = off[11:6] == REG_SLOT_ADDR[11:6];
  assign in_ctrl_rng = off[11:6] == REG_SLOT_CTRL[11:6];
  assign slot_ok     = {1'b0, off[5:2]} < 5'(NUM_VECTORS);

  assign raw_cur = ((item.source_levels & src_present) | soft_r) & SrcMask;
  assign irq_cur = raw_cur & enable_r & ~select_r;

  vic_prio #(.NUM_VECTORS(NUM_VECTORS)) u_prio_cur (
    .slot_ctrl  (slot_ctrl_r),
    .in_service (in_service_r),
    .irq_status (irq_cur),
    .prio       (prio_cur)
  );

  // one slot address read port, shared by offset reads and vector reads
  assign rd_idx      = (off == REG_VECT_ADDR) ? prio_cur.slot_idx : off[5:2];
  assign slot_addr_q = slot_addr_r[rd_idx[IdxW-1:0]];

  always_comb begin
    soft_nxt       = soft_r;
    enable_nxt     = enable_r;
    select_nxt     = select_r;
    protect_nxt    = protect_r;
    def_vect_nxt   = def_vect_r;
    in_service_nxt = in_service_r;
    slot_addr_nxt  = slot_addr_r;
    slot_ctrl_nxt  = slot_ctrl_r;
    rd_data        = '0;

    if (do_read) begin
      if (in_addr_rng) begin
        rd_data = slot_ok ? slot_addr_q : '0;
      end else if (in_ctrl_rng) begin
        rd_data = slot_ok ? {{(VIC_DATA_W-VIC_CTRL_W){1'b0}}, slot_ctrl_r[off[IdxW+1:2]]}
                          : '0;
      end else if (off >= REG_ID_BASE) begin
        rd_data = {{(VIC_DATA_W-8){1'b0}}, VIC_ID_BYTES[off[4:2]]};
      end else begin
        case (off)
          REG_IRQ_STATUS: rd_data = irq_cur;
          REG_FIQ_STATUS: rd_data = raw_cur & enable_r & select_r;
          REG_RAW_STATUS: rd_data = raw_cur;
          REG_SELECT:     rd_data = select_r;
          REG_ENABLE:     rd_data = enable_r;
          REG_SOFT:       rd_data = soft_r;
          REG_PROTECT:    rd_data = {{(VIC_DATA_W-1){1'b0}}, protect_r};
          REG_VECT_ADDR: begin
            if (prio_cur.found) begin
              in_service_nxt = in_service_r | (VIC_IS_W'(1) << prio_cur.slot_idx);
              rd_data        = slot_addr_q;
            end else begin
              if (prio_cur.is_default) begin
                in_service_nxt = in_service_r | (VIC_IS_W'(1) << (VIC_IS_W - 1));
              end
              rd_data = def_vect_r;
            end
          end
          REG_DEF_VECT:   rd_data = def_vect_r;
          default:        rd_data = '0;
        endcase
      end
    end

    if (do_write) begin
      if (in_addr_rng) begin
        if (slot_ok) begin
          slot_addr_nxt[off[IdxW+1:2]] = item.write_data;
        end
      end else if (in_ctrl_rng) begin
        if (slot_ok) begin
          slot_ctrl_nxt[off[IdxW+1:2]] = item.write_data[VIC_CTRL_W-1:0];
        end
      end else begin
        case (off)
          REG_SELECT:     select_nxt   = item.write_data & SrcMask;
          REG_ENABLE:     enable_nxt   = enable_r | (item.write_data & SrcMask);
          REG_ENABLE_CLR: enable_nxt   = enable_r & ~item.write_data;
          REG_SOFT:       soft_nxt     = soft_r | (item.write_data & SrcMask);
          REG_SOFT_CLR:   soft_nxt     = soft_r & ~item.write_data;
          REG_PROTECT:    protect_nxt  = item.write_data[0];
          // retire the highest level in service
          REG_VECT_ADDR:  in_service_nxt = in_service_r & (in_service_r - VIC_IS_W'(1));
          REG_DEF_VECT:   def_vect_nxt = item.write_data;
          default:        ;
        endcase
      end
    end
  end

  // request lines reflect the state after this access
  assign raw_new = ((item.source_levels & src_present) | soft_nxt) & SrcMask;
  assign irq_new = raw_new & enable_nxt & ~select_nxt;

  vic_prio #(.NUM_VECTORS(NUM_VECTORS)) u_prio_new (
    .slot_ctrl  (slot_ctrl_nxt),
    .in_service (in_service_nxt),
    .irq_status (irq_new),
    .prio       (prio_new)
  );

  assign result.read_data      = rd_data;
  assign result.irq_request    = prio_new.found || prio_new.is_default;
  assign result.fiq_request    = |(raw_new & enable_nxt & select_nxt);
  assign result.access_refused = refused;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r       <= '0;
      enable_r     <= '0;
      select_r     <= '0;
      protect_r    <= 1'b0;
      def_vect_r   <= '0;
      in_service_r <= '0;
      for (int i = 0; i < NUM_VECTORS; i++) begin
        slot_addr_r[i] <= '0;
        slot_ctrl_r[i] <= '0;
      end
    end else if (advance) begin
      soft_r       <= soft_nxt;
      enable_r     <= enable_nxt;
      select_r     <= select_nxt;
      protect_r    <= protect_nxt;
      def_vect_r   <= def_vect_nxt;
      in_service_r <= in_service_nxt;
      slot_addr_r  <= slot_addr_nxt;
      slot_ctrl_r  <= slot_ctrl_nxt;
    end
  end

endmodule

>>> rtl/core/vectored_interrupt_controller.sv
// ----------------------------------------------------------------------------
// vectored_interrupt_controller
// Vectored interrupt controller with soft, enable, FIQ-select and protection
// registers, vector slots and nested priority handling.
// ----------------------------------------------------------------------------
// Takes one access per clock while the result side keeps up: a transfer lands
// in the input register, is applied to the register file and priority search
// when it advances, and its result sits in the output register. The
// combinational path between the two registers is the access decode followed
// by the sixteen-slot priority search on the updated state. A new transfer is
// taken while a result still waits only if the input register is empty or advances.
module vectored_interrupt_controller #(
  parameter int NUM_SOURCES = vic_pkg::VIC_NUM_SOURCES,
  parameter int NUM_VECTORS = vic_pkg::VIC_NUM_VECTORS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [vic_pkg::VIC_DATA_W-1:0] cfg_wr_data,
  vic_in_if.sink                         in_ch,
  vic_out_if.source                      out_ch
);
  import vic_pkg::*;

  logic                  in_valid_r;
  vic_item_t             in_item_r;
  logic                  out_valid_r;
  vic_result_t           out_res_r;
  vic_result_t           res_nxt;
  logic [VIC_DATA_W-1:0] valid_src_r;
  logic                  advance;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  vic_regs #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_VECTORS (NUM_VECTORS)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (in_item_r),
    .src_present (valid_src_r),
    .result      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_src_r <= '1;
    end else begin
      if (cfg_wr_en) begin
        valid_src_r <= cfg_wr_data;
      end
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.opcode        <= in_ch.opcode;
      in_item_r.reg_offset    <= in_ch.reg_offset;
      in_item_r.write_data    <= in_ch.write_data;
      in_item_r.privileged    <= in_ch.privileged;
      in_item_r.source_levels <= in_ch.source_levels;
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_data      = out_res_r.read_data;
  assign out_ch.irq_request    = out_res_r.irq_request;
  assign out_ch.fiq_request    = out_res_r.fiq_request;
  assign out_ch.access_refused = out_res_r.access_refused;

  // a refused access never returns data
  a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.access_refused |-> out_res_r.read_data == '0)
    else $error("refused access returned read data");

  // a processed transfer always shows up as a result
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register empty after advance");

  // a held item is never dropped from the input register
  a_in_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("input item lost while stalled");

endmodule
